[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, off while reset is asserted (active low).
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Condition that must never be true on a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLKD(lbl, clk, rstn, !(expr), msg)

`endif

[design/shcb_pkg.sv]
package shcb_pkg;

    localparam int BIN_LIMIT_DFLT = 64;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 16;
    localparam int PT_IDX_W       = 6;
    localparam int PROD_W         = 32;

    localparam logic [PT_IDX_W-1:0] BINS_USED_RST = 6'd32;
    localparam logic [CNT_W-1:0]    CNT_MAX       = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_PT_MUL,
        ST_PT_DIV,
        ST_PT_OUT
    } shcb_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[design/symbol_histogram_cdf_builder.sv]
// Channel   Dir  Handshake          Beat contents
// s_        in   s_valid/s_ready    s_symbol, s_last
// m_        out  m_valid/m_ready    m_cdf_point, m_bin_index, m_last_point
// cfg_      in   cfg_wr_en          cfg_wr_data -> bins_used
//
// Steps: a sample is accepted with its counter read, then written back; a marked
// sample adds the total pass over mb bins, then per table point a multiply, 32
// divider steps, done and the output beat (multiply and beat only when the total
// is zero); mb is bins_used saturated to BIN_LIMIT-1.
// Reset: synchronous, active low; bins read as zero via per-bin valid flags.
// Stalls: s_ready is low until the sample or table is done; m_ready low holds.
`include "assert_macros.svh"

module symbol_histogram_cdf_builder import shcb_pkg::*; #(
    parameter int BIN_LIMIT = BIN_LIMIT_DFLT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [PT_IDX_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SYM_W-1:0]    s_symbol,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CNT_W-1:0]    m_cdf_point,
    output logic [PT_IDX_W-1:0] m_bin_index,
    output logic                m_last_point
);

    localparam int IW       = $clog2(BIN_LIMIT);
    localparam int MB_CAP_I = (BIN_LIMIT - 1 > 63) ? 63 : BIN_LIMIT - 1;
    localparam logic [PT_IDX_W-1:0] MB_CAP = PT_IDX_W'(MB_CAP_I);

    shcb_state_t state_reg, state_next;

    logic [PT_IDX_W-1:0]  bins_used_reg;
    logic [PT_IDX_W-1:0]  mb_reg, mb_next;
    logic [IW-1:0]        sym_reg, sym_next;
    logic                 hit_reg, hit_next;
    logic                 last_reg, last_next;
    logic [PT_IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     cdf_reg, cdf_next;
    logic [BIN_LIMIT-1:0] valid_reg, valid_next;
    logic                 rd_valid_reg;
    logic [CNT_W-1:0]     m_cdf_point_reg, m_cdf_point_next;
    logic [PT_IDX_W-1:0]  m_bin_index_reg, m_bin_index_next;
    logic                 m_last_point_reg, m_last_point_next;

    logic [PT_IDX_W-1:0]  mb_live;
    logic                 hit_live;
    logic                 accept;
    logic                 rd_en, wr_en, div_load;
    logic [IW-1:0]        rd_addr, wr_addr;
    logic [CNT_W-1:0]     wr_data, rd_data, count;
    logic [CNT_W-1:0]     scale;
    logic [PROD_W-1:0]    product, quotient;
    div_stat_t            div_stat;

    // saturate bins_used so every bin in use has a counter
    assign mb_live  = (bins_used_reg > MB_CAP) ? MB_CAP : bins_used_reg;
    assign hit_live = s_symbol < SYM_W'(mb_live);
    assign accept   = s_valid && s_ready;

    // unwritten bins read as zero
    assign count   = rd_valid_reg ? rd_data : '0;
    assign scale   = CNT_MAX - CNT_W'(mb_reg);
    assign product = PROD_W'(scale) * PROD_W'(cdf_reg);

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_PT_OUT);
    assign m_cdf_point  = m_cdf_point_reg;
    assign m_bin_index  = m_bin_index_reg;
    assign m_last_point = m_last_point_reg;

    shcb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BIN_LIMIT)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // product lands straight in the divider's shift register
    shcb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (div_load),
        .dividend (product),
        .divisor  (total_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (mb_reg == '0) begin
                    state_next = ST_PT_MUL;
                end else begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_SUM_RD: begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                if (idx_reg == mb_reg - 1'b1) begin
                    state_next = ST_PT_MUL;
                end else begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_PT_MUL: begin
                if (total_reg == '0) begin
                    state_next = ST_PT_OUT;
                end else begin
                    state_next = ST_PT_DIV;
                end
            end
            ST_PT_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_PT_OUT;
                end
            end
            ST_PT_OUT: begin
                if (m_ready) begin
                    state_next = m_last_point_reg ? ST_IDLE : ST_PT_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory and divider strobes
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = sym_reg;
        wr_data  = count + 1'b1;
        div_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_en   = accept && hit_live;
                rd_addr = IW'(s_symbol);
            end
            ST_UPD: begin
                wr_en = hit_reg;
            end
            ST_SUM_RD: begin
                rd_en   = 1'b1;
                rd_addr = IW'(idx_reg);
            end
            ST_PT_MUL: begin
                // fetch this bin's count for the next prefix sum
                rd_en    = 1'b1;
                rd_addr  = IW'(idx_reg);
                div_load = (total_reg != '0);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        mb_next           = mb_reg;
        sym_next          = sym_reg;
        hit_next          = hit_reg;
        last_next         = last_reg;
        idx_next          = idx_reg;
        total_next        = total_reg;
        cdf_next          = cdf_reg;
        valid_next        = valid_reg;
        m_cdf_point_next  = m_cdf_point_reg;
        m_bin_index_next  = m_bin_index_reg;
        m_last_point_next = m_last_point_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sym_next  = IW'(s_symbol);
                    hit_next  = hit_live;
                    last_next = s_last;
                    mb_next   = mb_live;
                end
            end
            ST_UPD: begin
                idx_next   = '0;
                total_next = '0;
                cdf_next   = '0;
                if (hit_reg) begin
                    valid_next[sym_reg] = 1'b1;
                end
            end
            ST_SUM_ACC: begin
                total_next = total_reg + count;
                idx_next   = (idx_reg == mb_reg - 1'b1) ? '0 : idx_reg + 1'b1;
            end
            ST_PT_MUL: begin
                // zero total: the point is just its index
                m_cdf_point_next  = CNT_W'(idx_reg);
                m_bin_index_next  = idx_reg;
                m_last_point_next = (idx_reg == mb_reg);
            end
            ST_PT_DIV: begin
                if (div_stat.done) begin
                    m_cdf_point_next = quotient[CNT_W-1:0] + CNT_W'(idx_reg);
                end
            end
            ST_PT_OUT: begin
                if (m_ready) begin
                    cdf_next = cdf_reg + count;
                    idx_next = idx_reg + 1'b1;
                    if (m_last_point_reg) begin
                        valid_next = '0;
                    end
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bins_used_reg <= BINS_USED_RST;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_wr_en) begin
                bins_used_reg <= cfg_wr_data;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        mb_reg           <= mb_next;
        sym_reg          <= sym_next;
        hit_reg          <= hit_next;
        last_reg         <= last_next;
        idx_reg          <= idx_next;
        total_reg        <= total_next;
        cdf_reg          <= cdf_next;
        m_cdf_point_reg  <= m_cdf_point_next;
        m_bin_index_reg  <= m_bin_index_next;
        m_last_point_reg <= m_last_point_next;
    end

    // input and output sides never open together
    `ASSERT_NEVER(a_in_out_excl, aclk, aresetn, s_ready && m_valid,
        "s_ready with m_valid")
    // final point taken: histogram empty and input open again
    `ASSERT_CLKD(a_clear_after_run, aclk, aresetn,
        (m_valid && m_ready && m_last_point) |=> (s_ready && valid_reg == '0),
        "histogram not cleared after table")
    // divider runs only while the sequencer waits for it
    `ASSERT_CLKD(a_div_owned, aclk, aresetn, div_stat.busy |-> (state_reg == ST_PT_DIV),
        "divider busy outside divide state")
    // emitted index stays inside the table
    `ASSERT_CLKD(a_index_range, aclk, aresetn, m_valid |-> (m_bin_index <= mb_reg),
        "table index beyond bins_used")

endmodule

[design/shcb_ram.sv]
module shcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/shcb_div.sv]
module shcb_div import shcb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [PROD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output div_stat_t         stat,
    output logic [PROD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(PROD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              fits;

    // one restoring-division bit per cycle, quotient bits shift in from the right
    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load) begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[PROD_W-2:0], fits};
            rem_next  = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load) begin
            den_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

[tb/tb_symbol_histogram_cdf_builder.sv]
`timescale 1ns / 100ps

module tb_symbol_histogram_cdf_builder import shcb_pkg::*;;

    localparam int BINS          = BIN_LIMIT_DFLT;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int REPORT_CAP    = 100;
    // Worst case: every sample ends a run of 64 points under heavy receiver
    // idling and the long hold-off; taken several times over.
    localparam int CYCLE_LIMIT   = 4_000_000;

    // One table point as it should leave the block.
    typedef struct packed {
        logic [CNT_W-1:0]    cdf;
        logic [PT_IDX_W-1:0] idx;
        logic                last;
    } table_point_t;

    // Tallies samples per bin, builds the scaled CDF on each run end and
    // checks output beats against the oldest expected point.
    class cdf_table_scoreboard;
        logic [CNT_W-1:0]    bin_tally [BINS];
        logic [PT_IDX_W-1:0] bins_used;
        table_point_t        expected_points [$];
        int                  errors;
        int                  samples;
        int                  tables;
        int                  points;

        function new();
            foreach (bin_tally[i]) bin_tally[i] = '0;
            bins_used = BINS_USED_RST;
            errors    = 0;
            samples   = 0;
            tables    = 0;
            points    = 0;
        endfunction

        function void set_bins_used(logic [PT_IDX_W-1:0] value);
            bins_used = value;
        endfunction

        function void note_sample(logic [SYM_W-1:0] sym, logic last);
            logic [CNT_W-1:0] total;
            logic [CNT_W-1:0] cdf;
            logic [31:0]      scale;
            logic [31:0]      value;
            table_point_t     pt;
            int unsigned      eff;
            int               i;
            eff = bins_used;
            samples++;
            if (sym < eff)
                bin_tally[sym] = bin_tally[sym] + 1'b1;
            if (!last)
                return;
            total = '0;
            for (i = 0; i < eff; i++)
                total = total + bin_tally[i];
            scale = 32'(CNT_MAX) - 32'(eff);
            cdf   = '0;
            for (i = 0; i <= eff; i++) begin
                if (total != '0)
                    value = (scale * 32'(cdf)) / 32'(total) + 32'(i);
                else
                    value = 32'(i);
                pt.cdf  = value[CNT_W-1:0];
                pt.idx  = PT_IDX_W'(i);
                pt.last = (i == eff);
                expected_points.push_back(pt);
                if (i < eff)
                    cdf = cdf + bin_tally[i];
            end
            foreach (bin_tally[j]) bin_tally[j] = '0;
            tables++;
        endfunction

        function void check_point(logic [CNT_W-1:0] cdf, logic [PT_IDX_W-1:0] idx,
                                  logic last);
            table_point_t exp_pt;
            points++;
            if (expected_points.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected point beat: cdf=%0d idx=%0d last=%0b",
                             $time, cdf, idx, last);
                return;
            end
            exp_pt = expected_points.pop_front();
            if (exp_pt.cdf !== cdf || exp_pt.idx !== idx || exp_pt.last !== last) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display({"%0t: point mismatch: expected cdf=%0d idx=%0d last=%0b,",
                              " actual cdf=%0d idx=%0d last=%0b"},
                             $time, exp_pt.cdf, exp_pt.idx, exp_pt.last, cdf, idx, last);
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [PT_IDX_W-1:0] cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [SYM_W-1:0]    s_symbol;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    logic [CNT_W-1:0]    m_cdf_point;
    logic [PT_IDX_W-1:0] m_bin_index;
    logic                m_last_point;

    cdf_table_scoreboard sb;

    int src_idle_pct  = 22;
    int sink_idle_pct = 66;
    int hold_off_left = 0;
    int cycle_count   = 0;
    int cfg_writes    = 0;
    int midrun_writes = 0;

    symbol_histogram_cdf_builder i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cdf_point  (m_cdf_point),
        .m_bin_index  (m_bin_index),
        .m_last_point (m_last_point)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort on a hung block.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d points still expected",
                     $time, cycle_count, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample both handshakes on the edge; everything here reads pre-edge values,
    // so the order against the block's own updates does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_point(m_cdf_point, m_bin_index, m_last_point);
            if (s_valid && s_ready)
                sb.note_sample(s_symbol, s_last);
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one sample beat, idling first at the sender's rate; hold the beat
    // until it is taken. Returns at the accepting edge.
    task automatic send_sample(input logic [SYM_W-1:0] sym, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_symbol <= sym;
        s_last   <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Drop valid, wait for every expected point, then let the last write-back
    // of a non-marked sample finish.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Pulse the register write; call only when the block is idle.
    task automatic write_bins_used(input logic [PT_IDX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_bins_used(value);
        cfg_writes++;
    endtask

    // Mostly small tables, sometimes the extremes or anything in range.
    function automatic logic [PT_IDX_W-1:0] pick_bins();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return PT_IDX_W'(BINS - 1);
        if (r <= 3)
            return PT_IDX_W'($urandom_range(BINS - 1));
        return PT_IDX_W'($urandom_range(8, 1));
    endfunction

    // Random runs: most symbols in use (or right at the edge), some anywhere;
    // occasional register changes between runs and inside a run.
    task automatic random_segment(input int n_items);
        int sent;
        int len;
        int mid;
        int k;
        logic [SYM_W-1:0] sym;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 30) begin
                wait_idle();
                write_bins_used(pick_bins());
            end
            len = $urandom_range(10, 1);
            mid = (len > 1 && $urandom_range(99) < 12) ? $urandom_range(len - 1, 1) : -1;
            for (k = 0; k < len; k++) begin
                if (k == mid) begin
                    wait_idle();
                    write_bins_used(pick_bins());
                    midrun_writes++;
                end
                if ($urandom_range(99) < 85)
                    sym = SYM_W'($urandom_range(sb.bins_used));
                else
                    sym = SYM_W'($urandom_range(255));
                send_sample(sym, k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        int k;
        sb = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_symbol    <= '0;
        s_last      <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset value of bins_used first.
        send_sample(8'd0, 1'b1);
        // Only an out-of-use symbol: zero total, points equal their index.
        send_sample(8'd255, 1'b1);
        send_sample(8'd31, 1'b0);
        send_sample(8'd32, 1'b0);
        send_sample(8'd31, 1'b0);
        send_sample(8'd5, 1'b0);
        send_sample(8'd31, 1'b1);

        // Widest table.
        wait_idle();
        write_bins_used(PT_IDX_W'(BINS - 1));
        send_sample(8'd62, 1'b0);
        send_sample(8'd63, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd62, 1'b1);

        // Single-point table: nothing is ever counted.
        wait_idle();
        write_bins_used('0);
        send_sample(8'd0, 1'b1);

        wait_idle();
        write_bins_used(PT_IDX_W'(1));
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd1, 1'b1);

        // Shrink mid-run: bin 7 stays counted but drops out of the table.
        wait_idle();
        write_bins_used(PT_IDX_W'(8));
        send_sample(8'd7, 1'b0);
        send_sample(8'd7, 1'b0);
        send_sample(8'd3, 1'b0);
        wait_idle();
        write_bins_used(PT_IDX_W'(4));
        midrun_writes++;
        send_sample(8'd2, 1'b0);
        send_sample(8'd1, 1'b1);

        // Grow mid-run.
        send_sample(8'd3, 1'b0);
        wait_idle();
        write_bins_used(PT_IDX_W'(10));
        midrun_writes++;
        send_sample(8'd9, 1'b1);

        // Sender idles a little, receiver a lot; start with a long hold-off
        // on a wide table while the next run is already being offered.
        wait_idle();
        write_bins_used(PT_IDX_W'(BINS - 1));
        hold_off_left = HOLD_OFF_LEN;
        for (k = 0; k < 4; k++)
            send_sample(SYM_W'($urandom_range(BINS - 1)), k == 3);
        for (k = 0; k < 3; k++)
            send_sample(SYM_W'($urandom_range(255)), k == 2);
        random_segment(95);

        // Swap the idling rates.
        src_idle_pct  = 66;
        sink_idle_pct = 22;
        random_segment(100);

        // Full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_segment(100);

        // Drain and let any stray beats show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d samples, %0d tables, %0d point beats checked, %0d mismatches.",
                 sb.samples, sb.tables, sb.points, sb.errors);
        $display("bins_used written %0d times (%0d mid-run), table sizes from 1 to 64 points.",
                 cfg_writes, midrun_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
